// ===== rtl/stbs_pkg.sv =====
// Shared types and constants for the sorted table bound search block.
// Used by stbs_ctrl, stbs_dpath and sorted_table_bound_search; no dependencies.
package stbs_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int DATA_W          = 32;
  localparam int MODE_W          = 3;
  localparam int SLOT_W          = 7;
  localparam int POS_W           = 7;
  localparam int LEN_W           = 8;

  localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MIN_EQ = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MIN_GE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MIN_GT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MAX_LT = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [SLOT_W-1:0]        entry_index;
    logic signed [DATA_W-1:0] key_or_data;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic read;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_search;
    logic empty;
    logic hit;
    logic out_free;
  } sts_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_EMIT
  } state_t;

endpackage

// ===== rtl/stbs_ctrl.sv =====
// Controller state machine for the sorted table bound search block.
// Depends on stbs_pkg; drives commands into stbs_dpath from its status.
module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = in_valid && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && sts.in_search) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        state_nxt = sts.empty ? S_EMIT : S_CMP;
      end
      S_CMP: begin
        state_nxt = sts.hit ? S_EMIT : S_PROBE;
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = accept;
      end
      S_PROBE: begin
        cmd.read = !sts.empty;
      end
      S_CMP: begin
        cmd.step = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/stbs_dpath.sv =====
// Datapath for the sorted table bound search block: table memory, length
// register, search bounds, probe compare and result register. Depends on stbs_pkg.
module stbs_dpath
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_word_t         in_data,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             out_stall,
  output logic             out_valid,
  output out_word_t        out_data,
  input  cmd_t             cmd,
  output sts_t             sts
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int LW    = (CW > LEN_W) ? CW : LEN_W;
  localparam int EW    = (CW > SLOT_W) ? CW : SLOT_W;

  logic [DATA_W-1:0]        mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  logic [LEN_W-1:0]         len_cfg_r;
  logic [MODE_W-1:0]        mode_r;
  logic signed [DATA_W-1:0] key_r;
  logic [CW-1:0]            lo_r, lo_nxt;
  logic [CW-1:0]            hi_r, hi_nxt;
  logic [IDX_W-1:0]         mid_r;
  logic                     found_r, found_nxt;
  logic [IDX_W-1:0]         pos_r, pos_nxt;
  logic                     out_valid_r;
  out_word_t                out_word_r;

  logic [CW-1:0]            len_clamp;
  logic [CW:0]              mid_sum;
  logic [IDX_W-1:0]         mid;
  logic                     slot_ok;
  logic                     is_max;
  logic                     last_one;
  logic                     go_right;
  logic                     match_ok;
  logic                     hit;

  always_comb begin
    if (LW'(len_cfg_r) > LW'(TABLE_DEPTH)) len_clamp = CW'(TABLE_DEPTH);
    else                                   len_clamp = CW'(len_cfg_r);
  end

  assign slot_ok = EW'(in_data.entry_index) < EW'(TABLE_DEPTH);
  assign is_max  = (mode_r == MODE_MAX_LT);
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} - {{CW{1'b0}}, !is_max};
  assign mid     = IDX_W'(mid_sum >> 1);

  assign last_one = ({1'b0, lo_r} + (CW+1)'(1)) == {1'b0, hi_r};

  always_comb begin
    if (mode_r == MODE_MIN_GT) go_right = (rd_data_r <= key_r);
    else                       go_right = (rd_data_r < key_r);
    match_ok = (mode_r != MODE_MIN_EQ) || (rd_data_r == key_r);
  end

  always_comb begin
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    found_nxt = found_r;
    pos_nxt   = pos_r;
    hit       = 1'b0;
    if (is_max) begin
      if (rd_data_r >= key_r) begin
        hi_nxt = CW'(mid_r);
      end else if (last_one) begin
        hit = 1'b1;
      end else begin
        lo_nxt = CW'(mid_r);
      end
    end else begin
      if (go_right) begin
        lo_nxt = CW'(mid_r) + CW'(1);
      end else if (!match_ok) begin
        hi_nxt = CW'(mid_r);
      end else if (last_one) begin
        hit = 1'b1;
      end else begin
        hi_nxt = CW'(mid_r) + CW'(1);
      end
    end
    if (hit) begin
      found_nxt = 1'b1;
      pos_nxt   = mid_r;
    end
  end

  assign sts.hit       = hit;
  assign sts.in_search = (in_data.mode == MODE_MIN_EQ) || (in_data.mode == MODE_MIN_GE) ||
                         (in_data.mode == MODE_MIN_GT) || (in_data.mode == MODE_MAX_LT);
  assign sts.empty     = !(lo_r < hi_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_data.mode == MODE_WRITE) && slot_ok) begin
      mem[IDX_W'(in_data.entry_index)] <= in_data.key_or_data;
    end
    if (cmd.read) begin
      rd_data_r <= mem[mid];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) len_cfg_r <= cfg_wdata;
      if (cmd.emit)            out_valid_r <= 1'b1;
      else if (!out_stall)     out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r  <= in_data.mode;
      key_r   <= in_data.key_or_data;
      lo_r    <= '0;
      hi_r    <= len_clamp;
      found_r <= 1'b0;
      pos_r   <= '0;
    end else if (cmd.step) begin
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      found_r <= found_nxt;
      pos_r   <= pos_nxt;
    end
    if (cmd.read) mid_r <= mid;
    if (cmd.emit) begin
      out_word_r.found    <= found_r;
      out_word_r.position <= POS_W'(pos_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

// ===== rtl/sorted_table_bound_search.sv =====
// Top level of the sorted table bound search block.
// Depends on stbs_pkg, stbs_ctrl and stbs_dpath.
//
// Write words (mode 0) load one table slot; slots at or beyond TABLE_DEPTH
// are dropped. Search words binary-search the first table_length entries
// (clamped to TABLE_DEPTH) and return one result word. A search makes P
// probes, at most about log2(table_length) + 1; each probe passes through
// S_PROBE, the registered read of the table memory, and then S_CMP, the
// compare and bound update. A search that finds no index ends with one more
// S_PROBE that finds the bounds empty. The result then waits in S_EMIT while
// the previous result still holds the output register under out_stall.
// Unused modes are accepted and dropped. One item is in work at a time; a
// finished result waits in the output register while the next item is taken.
// Entries never written read as unknown values.
module sorted_table_bound_search
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_data,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  stbs_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall &&
     (in_data.mode == MODE_MIN_EQ || in_data.mode == MODE_MIN_GE ||
      in_data.mode == MODE_MIN_GT || in_data.mode == MODE_MAX_LT)) |=> in_stall)
    else $error("search word did not hold off the input");

  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.mode == MODE_WRITE) |=> !in_stall)
    else $error("write word left the input stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.position == '0))
    else $error("miss result with nonzero position");

endmodule
